FILE: rtl/hpc_pkg.sv
// Shared widths, constants and result type for the Hilbert position-to-cell converter.
package hpc_pkg;

   localparam int POS_W             = 16;
   localparam int IDX_W             = 16;
   localparam int COORD_W           = 8;
   localparam int LEVEL_W           = 4;
   localparam int DEFAULT_MAX_LEVEL = 8;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd8;

   typedef struct packed {
      logic [IDX_W-1:0]   cell_index;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic               position_out_of_range;
   } cell_result_type;

endpackage

FILE: rtl/hpc_req_if.sv
// Input channel carrying one curve position per transfer.
interface hpc_req_if import hpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] curve_position;

   modport source (output valid, output curve_position, input ready);
   modport sink   (input valid, input curve_position, output ready);
endinterface

FILE: rtl/hpc_rsp_if.sv
// Result channel carrying one grid cell per transfer.
interface hpc_rsp_if import hpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   cell_index;
   logic [COORD_W-1:0] cell_x;
   logic [COORD_W-1:0] cell_y;
   logic               position_out_of_range;

   modport source (output valid, output cell_index, output cell_x, output cell_y,
                   output position_out_of_range, input ready);
   modport sink   (input valid, input cell_index, input cell_x, input cell_y,
                   input position_out_of_range, output ready);
endinterface

FILE: rtl/hpc_cfg.sv
// Curve level register, stored already clamped to the largest supported level.
module hpc_cfg import hpc_pkg::*; #(
   parameter int MAX_LEVEL = DEFAULT_MAX_LEVEL,
   parameter int LVL_W     = $clog2(MAX_LEVEL + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LEVEL_W-1:0] csr_wr_data,
   output logic [LVL_W-1:0]   level
);

   logic [LVL_W-1:0] level_ff;
   logic [LVL_W-1:0] level_in;
   logic [LVL_W-1:0] level_rst;

   always_comb begin
      if (32'(LEVEL_RESET) > MAX_LEVEL) begin
         level_rst = LVL_W'(MAX_LEVEL);
      end else begin
         level_rst = LVL_W'(LEVEL_RESET);
      end
      if (32'(csr_wr_data) > MAX_LEVEL) begin
         level_in = LVL_W'(MAX_LEVEL);
      end else begin
         level_in = LVL_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= level_rst;
      end else if (csr_wr_en) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

FILE: rtl/hpc_map.sv
// Combinational mapping from a curve position to its cell coordinates and index.
module hpc_map import hpc_pkg::*; #(
   parameter int MAX_LEVEL = DEFAULT_MAX_LEVEL,
   parameter int LVL_W     = $clog2(MAX_LEVEL + 1)
) (
   input  logic [POS_W-1:0] position,
   input  logic [LVL_W-1:0] level,
   output cell_result_type  result
);

   localparam int CW = (MAX_LEVEL > COORD_W) ? MAX_LEVEL : COORD_W;
   localparam int IW = (2 * MAX_LEVEL > IDX_W) ? 2 * MAX_LEVEL : IDX_W;
   localparam int PW = 2 * POS_W;

   logic [PW-1:0]        pos_w;
   logic [MAX_LEVEL-1:0] x;
   logic [MAX_LEVEL-1:0] y;
   logic [CW-1:0]        x_w;
   logic [CW-1:0]        y_w;
   logic [IW-1:0]        idx_w;
   logic                 swap;
   logic                 flip;
   logic                 base_x;
   logic                 base_y;
   logic [1:0]           quad;
   logic                 oor;

   assign pos_w = PW'(position);

   // Each outer quadrant swaps and/or inverts the coordinate bits below it, so the
   // bits are resolved from the outermost digit inward with a running swap/invert state.
   always_comb begin
      swap = 1'b0;
      flip = 1'b0;
      x    = '0;
      y    = '0;
      for (int k = MAX_LEVEL - 1; k >= 0; k--) begin
         quad   = pos_w[2*k +: 2];
         base_x = quad[1];
         base_y = ~(quad[1] ^ quad[0]);
         if (k < int'(level)) begin
            x[k] = (swap ? base_y : base_x) ^ flip;
            y[k] = (swap ? base_x : base_y) ^ flip;
            swap = swap ^ ~(quad[1] ^ quad[0]);
            flip = flip ^ (quad == 2'd0);
         end
      end
   end

   always_comb begin
      oor   = ((pos_w >> {level, 1'b0}) != '0);
      x_w   = CW'(x);
      y_w   = CW'(y);
      idx_w = IW'(x) | (IW'(y) << level);
      if (oor) begin
         result.cell_index = '0;
         result.cell_x     = '0;
         result.cell_y     = '0;
      end else begin
         result.cell_index = idx_w[IDX_W-1:0];
         result.cell_x     = x_w[COORD_W-1:0];
         result.cell_y     = y_w[COORD_W-1:0];
      end
      result.position_out_of_range = oor;
   end

endmodule

FILE: rtl/hilbert_position_to_cell_top.sv
// Top level of the Hilbert position-to-cell converter: input register, mapping, result register.
//
//   channel    direction  contents
//   req_chan   in         curve_position, valid/ready
//   rsp_chan   out        cell_index, cell_x, cell_y, position_out_of_range, valid/ready
//   csr_*      in         write of curve_level, taken on any cycle with csr_wr_en high
//
// One position per clock while results are taken. A position is held in the input register,
// mapped combinationally, and captured in the result register, which offers it on rsp_chan.
// A stall on rsp_chan can hold the item in the input register before that capture.
// Reset empties both stages and sets the level to 8 (clamped to MAX_LEVEL).
// A stalled result holds while the input stage can still take one more position.
module hilbert_position_to_cell_top import hpc_pkg::*; #(
   parameter int MAX_LEVEL = DEFAULT_MAX_LEVEL
) (
   input  logic               clock,
   input  logic               reset,
   hpc_req_if.sink            req_chan,
   hpc_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [LEVEL_W-1:0] csr_wr_data
);

   localparam int LVL_W = $clog2(MAX_LEVEL + 1);

   logic [LVL_W-1:0] level;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [POS_W-1:0] s1_pos_ff;
   logic             s2_valid_ff;
   logic             s2_valid_in;
   cell_result_type  s2_res_ff;
   cell_result_type  map_res;
   logic             s1_load;
   logic             s2_load;

   hpc_cfg #(
      .MAX_LEVEL (MAX_LEVEL),
      .LVL_W     (LVL_W)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .level       (level)
   );

   hpc_map #(
      .MAX_LEVEL (MAX_LEVEL),
      .LVL_W     (LVL_W)
   ) u_map (
      .position (s1_pos_ff),
      .level    (level),
      .result   (map_res)
   );

   always_comb begin
      s2_load        = !s2_valid_ff || rsp_chan.ready;
      req_chan.ready = !s1_valid_ff || s2_load;
      s1_load        = req_chan.valid && req_chan.ready;
      s1_valid_in    = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      s2_valid_in    = s2_load ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_pos_ff <= req_chan.curve_position;
      end
      if (s2_load && s1_valid_ff) begin
         s2_res_ff <= map_res;
      end
   end

   assign rsp_chan.valid                 = s2_valid_ff;
   assign rsp_chan.cell_index            = s2_res_ff.cell_index;
   assign rsp_chan.cell_x                = s2_res_ff.cell_x;
   assign rsp_chan.cell_y                = s2_res_ff.cell_y;
   assign rsp_chan.position_out_of_range = s2_res_ff.position_out_of_range;

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("pipeline not empty after reset");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_res_ff.position_out_of_range) |->
      (s2_res_ff.cell_index == '0 && s2_res_ff.cell_x == '0 && s2_res_ff.cell_y == '0))
      else $error("out-of-range result carries a nonzero cell");

   a_full_accept: assert property (@(posedge clock) disable iff (reset)
      (s1_load && s1_valid_ff) |-> s2_load)
      else $error("input stage overwritten while result stage stalled");

   a_stall_keep: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_chan.ready && s1_valid_ff) |=> (s1_valid_ff && s2_valid_ff))
      else $error("item dropped during output stall");
`endif

endmodule

FILE: sim/tb_hilbert_position_to_cell_top.sv
// Self-checking testbench for the Hilbert position-to-cell converter.
module tb_hilbert_position_to_cell_top import hpc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEVEL = DEFAULT_MAX_LEVEL;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 95;
   localparam int DIRECTED_ROWS = 22;

   typedef enum int unsigned {
      QUAD_BOTTOM_LEFT  = 0,
      QUAD_TOP_LEFT     = 1,
      QUAD_TOP_RIGHT    = 2,
      QUAD_BOTTOM_RIGHT = 3
   } quadrant_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   pos;
      logic               typed;
      cell_result_type    want;
   } stim_row_type;

   localparam cell_result_type OUT_OF_RANGE = '{16'd0, 8'd0, 8'd0, 1'b1};
   localparam cell_result_type CELL_ZERO    = '{16'd0, 8'd0, 8'd0, 1'b0};

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{4'd8,  16'd0,     1'b0, CELL_ZERO},
      '{4'd8,  16'hFFFF,  1'b0, CELL_ZERO},
      '{4'd8,  16'h5555,  1'b0, CELL_ZERO},
      '{4'd8,  16'hAAAA,  1'b0, CELL_ZERO},
      '{4'd0,  16'd0,     1'b1, CELL_ZERO},
      '{4'd0,  16'd1,     1'b1, OUT_OF_RANGE},
      '{4'd0,  16'hFFFF,  1'b1, OUT_OF_RANGE},
      '{4'd1,  16'd0,     1'b1, '{16'd2, 8'd0, 8'd1, 1'b0}},
      '{4'd1,  16'd1,     1'b1, CELL_ZERO},
      '{4'd1,  16'd2,     1'b1, '{16'd1, 8'd1, 8'd0, 1'b0}},
      '{4'd1,  16'd3,     1'b1, '{16'd3, 8'd1, 8'd1, 1'b0}},
      '{4'd1,  16'd4,     1'b1, OUT_OF_RANGE},
      '{4'd2,  16'd15,    1'b0, CELL_ZERO},
      '{4'd2,  16'd16,    1'b1, OUT_OF_RANGE},
      '{4'd4,  16'd255,   1'b0, CELL_ZERO},
      '{4'd4,  16'd256,   1'b1, OUT_OF_RANGE},
      '{4'd7,  16'd16383, 1'b0, CELL_ZERO},
      '{4'd7,  16'd16384, 1'b1, OUT_OF_RANGE},
      '{4'd9,  16'hFFFF,  1'b0, CELL_ZERO},
      '{4'd15, 16'd0,     1'b0, CELL_ZERO},
      '{4'd15, 16'hFFFF,  1'b0, CELL_ZERO},
      '{4'd15, 16'd12345, 1'b0, CELL_ZERO}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LEVEL_W-1:0] csr_wr_data;

   hpc_req_if req_if ();
   hpc_rsp_if rsp_if ();

   cell_result_type pending_cells[$];
   logic [LEVEL_W-1:0] cur_level;
   int unsigned mismatch_count;
   int unsigned source_calm;
   int unsigned sink_calm;
   int unsigned sink_stall;
   int unsigned sink_gap;

   hilbert_position_to_cell_top #(.MAX_LEVEL(MAX_LEVEL)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned effective_level(input logic [LEVEL_W-1:0] level);
      return (int'(level) > MAX_LEVEL) ? MAX_LEVEL : int'(level);
   endfunction

   function automatic cell_result_type map_position(input logic [LEVEL_W-1:0] level,
                                                    input logic [POS_W-1:0] pos);
      cell_result_type mapped;
      int unsigned eff;
      int unsigned x;
      int unsigned y;
      int unsigned h;
      int unsigned nx;
      int unsigned ny;
      quadrant_type quad;
      mapped = CELL_ZERO;
      eff = effective_level(level);
      if (32'(pos) >= (32'd1 << (2 * eff))) begin
         return OUT_OF_RANGE;
      end
      x = 0;
      y = 0;
      h = 1;
      for (int k = 0; k < int'(eff); k++) begin
         quad = quadrant_type'((32'(pos) >> (2 * k)) & 32'd3);
         case (quad)
            QUAD_BOTTOM_LEFT: begin
               nx = h - 1 - y;
               ny = (h - 1 - x) + h;
            end
            QUAD_TOP_LEFT: begin
               nx = x;
               ny = y;
            end
            QUAD_TOP_RIGHT: begin
               nx = x + h;
               ny = y;
            end
            default: begin
               nx = y + h;
               ny = x + h;
            end
         endcase
         x = nx;
         y = ny;
         h = h << 1;
      end
      mapped.cell_index = 16'(x + y * h);
      mapped.cell_x = 8'(x);
      mapped.cell_y = 8'(y);
      return mapped;
   endfunction

   // Mostly short gaps, a few long ones, and occasional stretches with none at all.
   function automatic int unsigned idle_cycles(inout int unsigned calm);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 199) == 0) begin
         calm = $urandom_range(50, 150);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_cell();
      cell_result_type want;
      if (pending_cells.size() == 0) begin
         report_mismatch("result transfer with nothing expected");
         return;
      end
      want = pending_cells.pop_front();
      if (rsp_if.cell_index !== want.cell_index) begin
         report_mismatch($sformatf("cell_index got %0d want %0d",
                                   rsp_if.cell_index, want.cell_index));
      end
      if (rsp_if.cell_x !== want.cell_x) begin
         report_mismatch($sformatf("cell_x got %0d want %0d", rsp_if.cell_x, want.cell_x));
      end
      if (rsp_if.cell_y !== want.cell_y) begin
         report_mismatch($sformatf("cell_y got %0d want %0d", rsp_if.cell_y, want.cell_y));
      end
      if (rsp_if.position_out_of_range !== want.position_out_of_range) begin
         report_mismatch($sformatf("position_out_of_range got %0b want %0b",
                                   rsp_if.position_out_of_range,
                                   want.position_out_of_range));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         sink_stall = 0;
         sink_calm = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_cell();
         end
         if (sink_stall > 0) begin
            rsp_if.ready <= 1'b0;
            sink_stall--;
         end else begin
            sink_gap = idle_cycles(sink_calm);
            if (sink_gap > 0) begin
               rsp_if.ready <= 1'b0;
               sink_stall = sink_gap - 1;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   task automatic wait_for_drain();
      while (pending_cells.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_level(input logic [LEVEL_W-1:0] level);
      req_if.valid <= 1'b0;
      wait_for_drain();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_level = level;
   endtask

   task automatic send_position(input logic [POS_W-1:0] pos, input logic typed,
                                input cell_result_type want);
      int unsigned gap;
      gap = idle_cycles(source_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.curve_position <= pos;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      pending_cells.push_back(typed ? want : map_position(cur_level, pos));
   endtask

   initial begin
      int unsigned eff;
      int unsigned limit;
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0] pos;
      mismatch_count = 0;
      source_calm = 0;
      cur_level = LEVEL_RESET;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= LEVEL_RESET;
      req_if.valid <= 1'b0;
      req_if.curve_position <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].level != cur_level) begin
            write_level(directed_rows[i].level);
         end
         send_position(directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: level = 4'd0;
            1: level = 4'd15;
            2: level = 4'd8;
            default: level = 4'($urandom_range(0, 15));
         endcase
         write_level(level);
         eff = effective_level(level);
         limit = 32'd1 << (2 * eff);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 85) begin
               pos = 16'($urandom_range(0, limit - 1));
            end else begin
               pos = 16'($urandom);
            end
            send_position(pos, 1'b0, CELL_ZERO);
         end
      end

      req_if.valid <= 1'b0;
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_hilbert_position_to_cell_top OK");
      end else begin
         $display("tb_hilbert_position_to_cell_top NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_hilbert_position_to_cell_top NOT OK");
      $finish;
   end

endmodule
